FILE: sv/sgds_pkg.sv
// Shared types, constants and helpers for the softened gravity direct-sum core.
// No dependencies; the files that use it refer to this package by scoped names.
package sgds_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } seq_state_t;

    typedef enum logic [1:0] {
        CFG_PARTICLE_COUNT = 2'd0,
        CFG_SOFTENING_SQ   = 2'd1,
        CFG_PARTICLE_MASS  = 2'd2,
        CFG_SELF_POTENTIAL = 2'd3
    } cfg_index_t;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [10:0] particle_count;
        logic [31:0] softening_sq;
        logic [31:0] particle_mass;
        logic [31:0] self_potential_offset;
    } cfg_t;

    localparam logic [10:0] RST_PARTICLE_COUNT = 11'd1024;
    localparam logic [31:0] RST_SOFTENING_SQ   = 32'd7;
    localparam logic [31:0] RST_PARTICLE_MASS  = 32'd8589934;
    localparam logic [31:0] RST_SELF_POTENTIAL = 32'd0;

    // 3 * 2^31, the Newton constant in Q1.31 terms
    localparam logic [33:0] NEWTON_K = 34'h1_8000_0000;
    localparam logic [62:0] N2_CAP   = 63'h4000_0000_0000_0000;
    localparam logic [62:0] TERM_CAP = 63'h7FFF_FFFF_FFFF_FFFF;

    // Seed for 1/sqrt, indexed by the top five bits of the normalised value less eight
    function automatic logic [14:0] seed_lookup(input logic [4:0] idx);
        logic [14:0] v;
        case (idx)
            5'd0:    v = 15'd31791;
            5'd1:    v = 15'd30070;
            5'd2:    v = 15'd28602;
            5'd3:    v = 15'd27330;
            5'd4:    v = 15'd26214;
            5'd5:    v = 15'd25225;
            5'd6:    v = 15'd24339;
            5'd7:    v = 15'd23541;
            5'd8:    v = 15'd22817;
            5'd9:    v = 15'd22155;
            5'd10:   v = 15'd21548;
            5'd11:   v = 15'd20988;
            5'd12:   v = 15'd20470;
            5'd13:   v = 15'd19988;
            5'd14:   v = 15'd19539;
            5'd15:   v = 15'd19119;
            5'd16:   v = 15'd18725;
            5'd17:   v = 15'd18354;
            5'd18:   v = 15'd18004;
            5'd19:   v = 15'd17674;
            5'd20:   v = 15'd17361;
            5'd21:   v = 15'd17064;
            5'd22:   v = 15'd16782;
            5'd23:   v = 15'd16514;
            default: v = 15'd0;
        endcase
        return v;
    endfunction

    // Saturating move of a signed accumulator by an unsigned magnitude
    function automatic logic [63:0] acc_move(input logic [63:0] acc, input logic [62:0] mag,
                                             input logic down);
        logic [64:0] r;
        if (down)
            r = {acc[63], acc} - {2'b00, mag};
        else
            r = {acc[63], acc} + {2'b00, mag};
        if (r[64:63] == 2'b10)
            return 64'h8000_0000_0000_0000;
        else if (r[64:63] == 2'b01)
            return 64'h7FFF_FFFF_FFFF_FFFF;
        else
            return r[63:0];
    endfunction

endpackage

FILE: sv/sgds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgds_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/sgds_newton.sv
// One Newton step for 1/sqrt in Q1.31, four registered stages, tag carried along.
// Uses sgds_pkg for the Newton constant.
module sgds_newton #(
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [TAG_W-1:0] in_tag,
    input  logic [31:0]      u_in,
    input  logic [31:0]      y_in,
    output logic             out_valid,
    output logic [TAG_W-1:0] out_tag,
    output logic [31:0]      u_out,
    output logic [31:0]      y_out
);

    logic             a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic [TAG_W-1:0] a_tag_reg, b_tag_reg, c_tag_reg, d_tag_reg;
    logic [31:0]      a_u_reg, b_u_reg, c_u_reg, d_u_reg;
    logic [31:0]      a_y_reg, b_y_reg, c_y_reg;
    logic [63:0]      a_yy_reg, b_uy_reg, d_yk_reg;
    logic [32:0]      c_k_reg;
    logic [33:0]      q;
    logic [32:0]      k_next;
    logic [64:0]      uy_full, yk_full;

    always_comb
    begin
        q = b_uy_reg[63:30];
        if (q > sgds_pkg::NEWTON_K)
            k_next = '0;
        else
            k_next = 33'(sgds_pkg::NEWTON_K - q);
        uy_full = 65'(a_u_reg) * 65'(a_yy_reg[63:31]);
        yk_full = 65'(c_y_reg) * 65'(c_k_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_tag_reg <= in_tag;
        a_u_reg   <= u_in;
        a_y_reg   <= y_in;
        a_yy_reg  <= 64'(y_in) * 64'(y_in);
        b_tag_reg <= a_tag_reg;
        b_u_reg   <= a_u_reg;
        b_y_reg   <= a_y_reg;
        b_uy_reg  <= uy_full[63:0];
        c_tag_reg <= b_tag_reg;
        c_u_reg   <= b_u_reg;
        c_y_reg   <= b_y_reg;
        c_k_reg   <= k_next;
        d_tag_reg <= c_tag_reg;
        d_u_reg   <= c_u_reg;
        d_yk_reg  <= yk_full[63:0];
    end

    assign out_valid = d_valid_reg;
    assign out_tag   = d_tag_reg;
    assign u_out     = d_u_reg;
    assign y_out     = d_yk_reg[63:32];

endmodule

FILE: sv/sgds_front.sv
// Front end: two-entry input queue that wraps coordinates and classifies items.
// Uses sgds_pkg for the opcode codes.
module sgds_front #(
    parameter int MAX_PARTICLES = 1024,
    parameter int COORD_BITS    = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                opcode,
    input  logic [9:0]                          slot,
    input  logic signed [31:0]                  pos_x,
    input  logic signed [31:0]                  pos_y,
    input  logic signed [31:0]                  pos_z,
    output logic                                item_valid,
    output logic                                item_query,
    output logic                                item_slot_ok,
    output logic [$clog2(MAX_PARTICLES)-1:0]    item_addr,
    output logic [2:0][COORD_BITS-1:0]          item_pos,
    input  logic                                item_pop
);

    localparam int AW = $clog2(MAX_PARTICLES);

    logic                       query_reg   [2];
    logic                       slot_ok_reg [2];
    logic [AW-1:0]              addr_reg    [2];
    logic [2:0][COORD_BITS-1:0] pos_reg     [2];
    logic                       wr_ptr_reg, rd_ptr_reg;
    logic [1:0]                 count_reg;
    logic                       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = item_pop && item_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= 2'(count_reg + {1'b0, do_push} - {1'b0, do_pop});
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            query_reg[wr_ptr_reg]   <= (opcode == sgds_pkg::OP_QUERY);
            slot_ok_reg[wr_ptr_reg] <= (32'(slot) < 32'(MAX_PARTICLES));
            addr_reg[wr_ptr_reg]    <= AW'(slot);
            // sign-extend, then wrap to the stored coordinate width
            pos_reg[wr_ptr_reg][0]  <= COORD_BITS'(pos_x);
            pos_reg[wr_ptr_reg][1]  <= COORD_BITS'(pos_y);
            pos_reg[wr_ptr_reg][2]  <= COORD_BITS'(pos_z);
        end
    end

    assign item_valid   = (count_reg != 2'd0);
    assign item_query   = query_reg[rd_ptr_reg];
    assign item_slot_ok = slot_ok_reg[rd_ptr_reg];
    assign item_addr    = addr_reg[rd_ptr_reg];
    assign item_pos     = pos_reg[rd_ptr_reg];

endmodule

FILE: sv/sgds_back.sv
// Back end: sequencer over the position table, pipelined pair unit and accumulators.
// Uses sgds_pkg, sgds_ram and sgds_newton.
module sgds_back #(
    parameter int MAX_PARTICLES = 1024,
    parameter int COORD_BITS    = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  logic                             item_query,
    input  logic                             item_slot_ok,
    input  logic [$clog2(MAX_PARTICLES)-1:0] item_addr,
    input  logic [2:0][COORD_BITS-1:0]       item_pos,
    output logic                             item_pop,
    input  sgds_pkg::cfg_t                   cfg,
    input  logic                             res_free,
    output logic                             res_valid,
    output logic [2:0][63:0]                 res_accel,
    output logic [63:0]                      res_potential
);

    localparam int AW = $clog2(MAX_PARTICLES);
    localparam int DW = COORD_BITS + 1;

    typedef struct packed {
        logic                 last;
        logic                 skip;
        logic signed [5:0]    h;
        logic [2:0]           pos;
        logic [2:0]           nz;
        logic [2:0][DW-1:0]   mag;
    } side_t;

    localparam int TW = $bits(side_t);

    // ---------------- sequencer ----------------
    sgds_pkg::seq_state_t       state_reg, state_next;
    logic [AW-1:0]              j_reg, last_idx_reg;
    logic [2:0][COORD_BITS-1:0] q_reg;
    logic                       issue, start, direct_res, ram_we, done;
    logic [31:0]                cnt32;
    logic                       cnt_zero;
    logic [63:0]                pot_init;

    always_comb
    begin
        if (32'(cfg.particle_count) > 32'(MAX_PARTICLES))
            cnt32 = 32'(MAX_PARTICLES);
        else
            cnt32 = 32'(cfg.particle_count);
        cnt_zero = (cnt32 == 32'd0);
        pot_init = {16'd0, cfg.self_potential_offset, 16'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sgds_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        item_pop   = 1'b0;
        ram_we     = 1'b0;
        issue      = 1'b0;
        start      = 1'b0;
        direct_res = 1'b0;
        case (state_reg)
            sgds_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (!item_query)
                    begin
                        ram_we   = item_slot_ok;
                        item_pop = 1'b1;
                    end
                    else if (res_free)
                    begin
                        item_pop = 1'b1;
                        if (cnt_zero)
                            direct_res = 1'b1;
                        else
                        begin
                            start      = 1'b1;
                            state_next = sgds_pkg::ST_RUN;
                        end
                    end
                end
            end
            sgds_pkg::ST_RUN:
            begin
                issue = 1'b1;
                if (j_reg == last_idx_reg)
                    state_next = sgds_pkg::ST_DRAIN;
            end
            sgds_pkg::ST_DRAIN:
            begin
                if (done)
                    state_next = sgds_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sgds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg        <= item_pos;
            j_reg        <= '0;
            last_idx_reg <= AW'(cnt32 - 32'd1);
        end
        else if (issue)
            j_reg <= AW'(j_reg + 1'b1);
    end

    // ---------------- position table ----------------
    logic [3*COORD_BITS-1:0]    ram_rdata;
    logic [2:0][COORD_BITS-1:0] ent;

    sgds_ram #(
        .WIDTH(3 * COORD_BITS),
        .DEPTH(MAX_PARTICLES)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(item_addr),
        .wdata(item_pos),
        .raddr(j_reg),
        .rdata(ram_rdata)
    );

    assign ent = ram_rdata;

    // ---------------- pair pipeline ----------------
    logic            s1_valid_reg, s1_last_reg;
    logic            s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic            s7_valid_reg;
    side_t           s2_side_reg, s3_side_reg, s4_side_reg, s5_side_reg, s6_side_reg;
    side_t           s7_side_reg;
    logic [2:0]      s3_big_reg;
    logic [2:0][37:0] s3_hh_reg;
    logic [2:0][38:0] s3_hl_reg;
    logic [2:0][39:0] s3_ll_reg;
    logic [2:0][62:0] s4_sq_reg;
    logic [62:0]     s5_n_reg, s6_n_reg;
    logic [5:0]      s6_b_reg;
    logic [31:0]     s7_u_reg, s7_y_reg;

    side_t           s1_side, s5_side_in, s7_side_in;
    logic [2:0][COORD_BITS:0] d;
    logic [2:0][63:0] m64;
    logic [2:0][62:0] sq;
    logic [2:0][77:0] sq_full;
    logic [64:0]     n_full;
    logic [62:0]     n_cap;
    logic [5:0]      msb;
    logic signed [6:0] shv;
    logic [5:0]      nsh;
    logic [62:0]     n_shift;
    logic [31:0]     u_norm;
    logic signed [6:0] h_wide;
    logic [4:0]      seed_idx;

    always_comb
    begin
        s1_side      = '0;
        s1_side.last = s1_last_reg;
        for (int c = 0; c < 3; c++)
        begin
            d[c] = {q_reg[c][COORD_BITS-1], q_reg[c]} - {ent[c][COORD_BITS-1], ent[c]};
            if (d[c][COORD_BITS])
                s1_side.mag[c] = DW'(-d[c]);
            else
                s1_side.mag[c] = DW'(d[c]);
            s1_side.nz[c]  = (d[c] != '0);
            s1_side.pos[c] = !d[c][COORD_BITS] && (d[c] != '0);
            m64[c]         = 64'(s2_side_reg.mag[c]);
            sq_full[c]     = {s3_hh_reg[c], 40'd0} + {s3_hl_reg[c], 21'd0}
                             + 78'(s3_ll_reg[c]);
            if (s3_big_reg[c])
                sq[c] = sgds_pkg::N2_CAP;
            else
                sq[c] = {1'b0, sq_full[c][77:16]};
        end
        n_full = 65'(s4_sq_reg[0]) + 65'(s4_sq_reg[1]) + 65'(s4_sq_reg[2])
                 + 65'(cfg.softening_sq);
        if (n_full > 65'(sgds_pkg::N2_CAP))
            n_cap = sgds_pkg::N2_CAP;
        else
            n_cap = n_full[62:0];
        s5_side_in      = s4_side_reg;
        s5_side_in.skip = (n_cap == '0);
        msb = '0;
        for (int i = 0; i < 63; i++)
            if (s5_n_reg[i])
                msb = 6'(i);
        // even shift that puts the value in [2^30, 2^32)
        shv = $signed({1'b0, s6_b_reg}) - 7'sd30 - $signed({6'd0, s6_b_reg[0]});
        nsh = 6'(-shv);
        if (!shv[6])
            n_shift = s6_n_reg >> shv[5:0];
        else
            n_shift = s6_n_reg << nsh;
        u_norm   = n_shift[31:0];
        h_wide   = (shv + 7'sd14) >>> 1;
        seed_idx = 5'(u_norm[31:27] - 5'd8);
        s7_side_in   = s6_side_reg;
        s7_side_in.h = 6'(h_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= issue && (j_reg == last_idx_reg);
        s2_side_reg <= s1_side;
        s3_side_reg <= s2_side_reg;
        for (int c = 0; c < 3; c++)
        begin
            s3_big_reg[c] <= (m64[c][63:39] != '0);
            s3_hh_reg[c]  <= 38'(m64[c][38:20]) * 38'(m64[c][38:20]);
            s3_hl_reg[c]  <= 39'(m64[c][38:20]) * 39'(m64[c][19:0]);
            s3_ll_reg[c]  <= 40'(m64[c][19:0]) * 40'(m64[c][19:0]);
        end
        s4_side_reg      <= s3_side_reg;
        s4_sq_reg        <= sq;
        s5_side_reg      <= s5_side_in;
        s5_n_reg         <= n_cap;
        s6_side_reg      <= s5_side_reg;
        s6_n_reg         <= s5_n_reg;
        s6_b_reg         <= msb;
        s7_side_reg      <= s7_side_in;
        s7_u_reg         <= u_norm;
        s7_y_reg         <= {1'b0, sgds_pkg::seed_lookup(seed_idx), 16'd0};
    end

    // ---------------- Newton iterations ----------------
    logic          n1_valid, n2_valid;
    logic [TW-1:0] n1_tag, n2_tag;
    logic [31:0]   n1_u, n1_y, n2_y;

    sgds_newton #(.TAG_W(TW)) u_newton_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s7_valid_reg),
        .in_tag   (s7_side_reg),
        .u_in     (s7_u_reg),
        .y_in     (s7_y_reg),
        .out_valid(n1_valid),
        .out_tag  (n1_tag),
        .u_out    (n1_u),
        .y_out    (n1_y)
    );

    sgds_newton #(.TAG_W(TW)) u_newton_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (n1_valid),
        .in_tag   (n1_tag),
        .u_in     (n1_u),
        .y_in     (n1_y),
        .out_valid(n2_valid),
        .out_tag  (n2_tag),
        .u_out    (),
        .y_out    (n2_y)
    );

    // ---------------- force and potential terms ----------------
    logic              t1_valid_reg, t2_valid_reg, t3_valid_reg, t4_valid_reg;
    logic              t5_valid_reg, t6_valid_reg, t7_valid_reg;
    side_t             t1_side_reg, t2_side_reg, t3_side_reg, t4_side_reg;
    side_t             t5_side_reg, t6_side_reg, t7_side_reg;
    logic [31:0]       t1_y_reg;
    logic [63:0]       t1_pt_reg, t1_yy_reg, t2_yyy_reg, t3_my3_reg;
    logic [62:0]       t2_pot_reg, t3_pot_reg, t4_pot_reg, t5_pot_reg;
    logic [62:0]       t6_pot_reg, t7_pot_reg;
    logic [40:0]       t4_p_reg;
    logic [6:0]        t4_sa_reg, t5_sa_reg, t6_sa_reg;
    logic [2:0][45:0]  t5_ll_reg, t5_lh_reg;
    logic [2:0][44:0]  t5_hl_reg, t5_hh_reg;
    logic [2:0][90:0]  t6_full_reg;
    logic [2:0][62:0]  t7_term_reg;

    side_t             n2_side;
    logic signed [7:0] hx, psh, s_val, s_neg;
    logic [63:0]       pot_shifted;
    logic [64:0]       yyy_full, my3_full;
    logic [32:0]       p0;
    logic [40:0]       p_adj;
    logic [6:0]        sa_adj;
    logic [2:0][49:0]  m50;
    logic [2:0][90:0]  full_sum, shifted;
    logic [2:0][62:0]  term;

    always_comb
    begin
        n2_side     = n2_tag;
        hx          = 8'(t1_side_reg.h);
        psh         = hx + 8'sd31;
        pot_shifted = t1_pt_reg >> psh[5:0];
        yyy_full    = 65'(t1_yy_reg[63:31]) * 65'(t1_y_reg);
        my3_full    = 65'(cfg.particle_mass) * 65'(t2_yyy_reg[63:31]);
        p0          = t3_my3_reg[63:31];
        s_val       = 8'sd16 + 8'sd3 * 8'(t3_side_reg.h);
        s_neg       = -s_val;
        if (s_val < 0)
        begin
            p_adj  = 41'(p0) << s_neg[3:0];
            sa_adj = '0;
        end
        else
        begin
            p_adj  = 41'(p0);
            sa_adj = s_val[6:0];
        end
        for (int c = 0; c < 3; c++)
        begin
            m50[c]      = 50'(t4_side_reg.mag[c]);
            full_sum[c] = 91'(t5_ll_reg[c]) + {20'd0, t5_lh_reg[c], 25'd0}
                          + {25'd0, t5_hl_reg[c], 21'd0} + {t5_hh_reg[c], 46'd0};
            shifted[c]  = t6_full_reg[c] >> t6_sa_reg;
            if (shifted[c][90:63] != '0)
                term[c] = sgds_pkg::TERM_CAP;
            else
                term[c] = shifted[c][62:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
            t3_valid_reg <= 1'b0;
            t4_valid_reg <= 1'b0;
            t5_valid_reg <= 1'b0;
            t6_valid_reg <= 1'b0;
            t7_valid_reg <= 1'b0;
        end
        else
        begin
            t1_valid_reg <= n2_valid;
            t2_valid_reg <= t1_valid_reg;
            t3_valid_reg <= t2_valid_reg;
            t4_valid_reg <= t3_valid_reg;
            t5_valid_reg <= t4_valid_reg;
            t6_valid_reg <= t5_valid_reg;
            t7_valid_reg <= t6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_side_reg <= n2_side;
        t1_y_reg    <= n2_y;
        t1_pt_reg   <= 64'(cfg.particle_mass) * 64'(n2_y);
        t1_yy_reg   <= 64'(n2_y) * 64'(n2_y);
        t2_side_reg <= t1_side_reg;
        t2_pot_reg  <= pot_shifted[62:0];
        t2_yyy_reg  <= yyy_full[63:0];
        t3_side_reg <= t2_side_reg;
        t3_pot_reg  <= t2_pot_reg;
        t3_my3_reg  <= my3_full[63:0];
        t4_side_reg <= t3_side_reg;
        t4_pot_reg  <= t3_pot_reg;
        t4_p_reg    <= p_adj;
        t4_sa_reg   <= sa_adj;
        t5_side_reg <= t4_side_reg;
        t5_pot_reg  <= t4_pot_reg;
        t5_sa_reg   <= t4_sa_reg;
        for (int c = 0; c < 3; c++)
        begin
            t5_ll_reg[c] <= 46'(t4_p_reg[20:0]) * 46'(m50[c][24:0]);
            t5_lh_reg[c] <= 46'(t4_p_reg[20:0]) * 46'(m50[c][49:25]);
            t5_hl_reg[c] <= 45'(t4_p_reg[40:21]) * 45'(m50[c][24:0]);
            t5_hh_reg[c] <= 45'(t4_p_reg[40:21]) * 45'(m50[c][49:25]);
        end
        t6_side_reg <= t5_side_reg;
        t6_pot_reg  <= t5_pot_reg;
        t6_sa_reg   <= t5_sa_reg;
        t6_full_reg <= full_sum;
        t7_side_reg <= t6_side_reg;
        t7_pot_reg  <= t6_pot_reg;
        t7_term_reg <= term;
    end

    // ---------------- accumulators ----------------
    logic [2:0][63:0] acc_reg, acc_next;
    logic [63:0]      pot_reg, pot_next;

    always_comb
    begin
        acc_next = acc_reg;
        pot_next = pot_reg;
        if (start)
        begin
            acc_next = '0;
            pot_next = pot_init;
        end
        else if (t7_valid_reg && !t7_side_reg.skip)
        begin
            pot_next = sgds_pkg::acc_move(pot_reg, t7_pot_reg, 1'b1);
            for (int c = 0; c < 3; c++)
                if (t7_side_reg.nz[c])
                    acc_next[c] = sgds_pkg::acc_move(acc_reg[c], t7_term_reg[c],
                                                     t7_side_reg.pos[c]);
        end
        done = t7_valid_reg && t7_side_reg.last;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        pot_reg <= pot_next;
    end

    assign res_valid     = direct_res || done;
    assign res_accel     = direct_res ? '0 : acc_next;
    assign res_potential = direct_res ? pot_init : pot_next;

endmodule

FILE: sv/softened_gravity_direct_sum_core.sv
// Softened gravity direct-sum core: configuration registers, result register and
// the front/back split. Depends on sgds_pkg, sgds_front and sgds_back.
//
// Usage:
//   Input queue: drive opcode, slot and pos_x/y/z and raise push; a transaction
//   completes when push is high and full is low. A store writes one table
//   slot. A query walks table entries 0 .. particle_count-1 (the count is capped
//   at MAX_PARTICLES) through a pair pipeline that takes one particle per
//   cycle, and the back end takes no new item until the pipeline (table read,
//   squares, normalise, two Newton steps, force product, shift) has drained.
//   A count of zero answers without walking the table.
//   Result queue: while empty is low the result sits on accel_x/y/z and
//   potential; pop takes it. If the receiver stalls, the result is held and
//   the two-entry input queue keeps taking items until it fills; the next
//   query then waits for the result register to drain.
//   Configuration: cfg_index/cfg_data with cfg_valid; cfg_ready is always high.
//   Write only while no item is in flight.
//   Reset: queues empty, registers at their reset values; the table is not
//   cleared and every slot must be stored before a query reads it.
module softened_gravity_direct_sum_core #(
    parameter int MAX_PARTICLES = 1024,
    parameter int COORD_BITS    = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               opcode,
    input  logic [9:0]         slot,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               empty,
    input  logic               pop,
    output logic signed [63:0] accel_x,
    output logic signed [63:0] accel_y,
    output logic signed [63:0] accel_z,
    output logic signed [63:0] potential,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int AW = $clog2(MAX_PARTICLES);

    sgds_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.particle_count        <= sgds_pkg::RST_PARTICLE_COUNT;
            cfg_reg.softening_sq          <= sgds_pkg::RST_SOFTENING_SQ;
            cfg_reg.particle_mass         <= sgds_pkg::RST_PARTICLE_MASS;
            cfg_reg.self_potential_offset <= sgds_pkg::RST_SELF_POTENTIAL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sgds_pkg::cfg_index_t'(cfg_index))
                sgds_pkg::CFG_PARTICLE_COUNT: cfg_reg.particle_count        <= cfg_data[10:0];
                sgds_pkg::CFG_SOFTENING_SQ:   cfg_reg.softening_sq          <= cfg_data;
                sgds_pkg::CFG_PARTICLE_MASS:  cfg_reg.particle_mass         <= cfg_data;
                sgds_pkg::CFG_SELF_POTENTIAL: cfg_reg.self_potential_offset <= cfg_data;
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    logic                       item_valid, item_query, item_slot_ok, item_pop;
    logic [AW-1:0]              item_addr;
    logic [2:0][COORD_BITS-1:0] item_pos;

    sgds_front #(
        .MAX_PARTICLES(MAX_PARTICLES),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .opcode      (opcode),
        .slot        (slot),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .item_valid  (item_valid),
        .item_query  (item_query),
        .item_slot_ok(item_slot_ok),
        .item_addr   (item_addr),
        .item_pos    (item_pos),
        .item_pop    (item_pop)
    );

    logic             out_valid_reg;
    logic             res_valid;
    logic [2:0][63:0] res_accel;
    logic [63:0]      res_potential;
    logic [2:0][63:0] out_accel_reg;
    logic [63:0]      out_pot_reg;

    sgds_back #(
        .MAX_PARTICLES(MAX_PARTICLES),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_query   (item_query),
        .item_slot_ok (item_slot_ok),
        .item_addr    (item_addr),
        .item_pos     (item_pos),
        .item_pop     (item_pop),
        .cfg          (cfg_reg),
        .res_free     (!out_valid_reg),
        .res_valid    (res_valid),
        .res_accel    (res_accel),
        .res_potential(res_potential)
    );

    // Hold one result until it is popped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_accel_reg <= res_accel;
            out_pot_reg   <= res_potential;
        end
    end

    assign empty     = !out_valid_reg;
    assign accel_x   = out_accel_reg[0];
    assign accel_y   = out_accel_reg[1];
    assign accel_z   = out_accel_reg[2];
    assign potential = out_pot_reg;

endmodule

FILE: sim/tb_softened_gravity_direct_sum_core.sv
// Testbench for softened_gravity_direct_sum_core: stores and queries in bursts, with
// the accelerations and potential worked out in-bench and checked per result.
// Depends on sgds_pkg and the core RTL.
module tb_softened_gravity_direct_sum_core;

    localparam int TABLE_DEPTH = 1024;
    localparam logic [63:0] SQ_CAP   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] MAG_CAP  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEWTON3  = 64'h1_8000_0000;

    typedef struct {
        logic              op;
        logic [9:0]        slot;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } body_item_t;

    typedef struct {
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] az;
        logic [63:0] pot;
    } field_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic opcode = sgds_pkg::OP_STORE;
    logic [9:0] slot = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic empty;
    logic pop = 1'b0;
    logic signed [63:0] accel_x, accel_y, accel_z, potential;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    softened_gravity_direct_sum_core dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .opcode(opcode),
        .slot(slot), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .empty(empty),
        .pop(pop), .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .potential(potential), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    body_item_t    pending_items[$];
    field_result_t expected_fields[$];
    bit            failed = 1'b0;

    // bench copy of the block state
    logic signed [31:0] stored_pos[TABLE_DEPTH][3];
    logic [10:0] cur_count = sgds_pkg::RST_PARTICLE_COUNT;
    logic [63:0] cur_eps2  = 64'(sgds_pkg::RST_SOFTENING_SQ);
    logic [63:0] cur_mass  = 64'(sgds_pkg::RST_PARTICLE_MASS);
    logic [63:0] cur_offset = 64'(sgds_pkg::RST_SELF_POTENTIAL);

    // generation-side record of written slots
    bit slot_written[TABLE_DEPTH];

    logic [15:0] rsqrt_seed[24] = '{
        31791, 30070, 28602, 27330, 26214, 25225, 24339, 23541,
        22817, 22155, 21548, 20988, 20470, 19988, 19539, 19119,
        18725, 18354, 18004, 17674, 17361, 17064, 16782, 16514
    };

    function automatic logic [63:0] square_q16(logic [63:0] a);
        logic [63:0] hi, lo, v;
        if (a >= 64'h80_0000_0000)
            return SQ_CAP;
        hi = a >> 16;
        lo = a & 64'hFFFF;
        v = ((hi * hi) << 16) + 64'd2 * hi * lo + ((lo * lo) >> 16);
        return (v > SQ_CAP) ? SQ_CAP : v;
    endfunction

    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> s;
        return (p > {64'd0, MAG_CAP}) ? MAG_CAP : p[63:0];
    endfunction

    function automatic logic [63:0] sat_move(logic [63:0] acc, logic [63:0] mag, bit down);
        logic signed [64:0] r;
        r = down ? $signed({acc[63], acc}) - $signed({1'b0, mag})
                 : $signed({acc[63], acc}) + $signed({1'b0, mag});
        if (r < -65'sh8000_0000_0000_0000)
            return 64'h8000_0000_0000_0000;
        if (r > 65'sh7FFF_FFFF_FFFF_FFFF)
            return 64'h7FFF_FFFF_FFFF_FFFF;
        return r[63:0];
    endfunction

    function automatic logic [63:0] recip_root(logic [63:0] n, output int half);
        int b, sh;
        logic [63:0] u, y, y2, q, k;
        b = 62;
        while (b > 0 && n[b] == 1'b0)
            b--;
        sh = b - 30 - (b & 1);
        u = (sh >= 0) ? (n >> sh) : (n << (-sh));
        half = (sh + 14) / 2;
        y = 64'(rsqrt_seed[((u >> 27) - 64'd8) & 64'd31]) << 16;
        for (int i = 0; i < 2; i++)
        begin
            y2 = (y * y) >> 31;
            q = (u * y2) >> 30;
            k = (q > NEWTON3) ? 64'd0 : NEWTON3 - q;
            y = (y * k) >> 32;
        end
        return y;
    endfunction

    function automatic field_result_t gravity_sum(body_item_t it);
        field_result_t r;
        logic [63:0] acc[3];
        logic [63:0] pot, n, y, y3, p;
        logic signed [63:0] d[3];
        logic [63:0] mag;
        int half, s, cnt;
        acc = '{64'd0, 64'd0, 64'd0};
        pot = cur_offset << 16;
        cnt = int'(cur_count);
        if (cnt > TABLE_DEPTH)
            cnt = TABLE_DEPTH;
        for (int j = 0; j < cnt; j++)
        begin
            n = cur_eps2;
            d[0] = 64'(it.x) - 64'(stored_pos[j][0]);
            d[1] = 64'(it.y) - 64'(stored_pos[j][1]);
            d[2] = 64'(it.z) - 64'(stored_pos[j][2]);
            for (int c = 0; c < 3; c++)
            begin
                mag = (d[c] < 0) ? -d[c] : d[c];
                n += square_q16(mag);
            end
            if (n > SQ_CAP)
                n = SQ_CAP;
            if (n == 0)
                continue;
            y = recip_root(n, half);
            pot = sat_move(pot, scaled_product(cur_mass, y, 31 + half), 1'b1);
            y3 = (((y * y) >> 31) * y) >> 31;
            p = (cur_mass * y3) >> 31;
            s = 16 + 3 * half;
            if (s < 0)
            begin
                p = p << (-s);
                s = 0;
            end
            for (int c = 0; c < 3; c++)
            begin
                if (d[c] == 0)
                    continue;
                mag = (d[c] < 0) ? -d[c] : d[c];
                acc[c] = sat_move(acc[c], scaled_product(p, mag, s), d[c] > 0);
            end
        end
        r.ax = acc[0];
        r.ay = acc[1];
        r.az = acc[2];
        r.pot = pot;
        return r;
    endfunction

    // driver: bursts of pushes separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                if (opcode == sgds_pkg::OP_QUERY)
                    expected_fields.push_back(gravity_sum('{opcode, slot, pos_x, pos_y, pos_z}));
                else
                begin
                    stored_pos[slot][0] = pos_x;
                    stored_pos[slot][1] = pos_y;
                    stored_pos[slot][2] = pos_z;
                end
            end
            if (!push || !full)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    push <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    body_item_t nxt;
                    nxt = pending_items.pop_front();
                    opcode <= nxt.op;
                    slot <= nxt.slot;
                    pos_x <= nxt.x;
                    pos_y <= nxt.y;
                    pos_z <= nxt.z;
                    push <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // monitor: check each result transaction, stall on a shifting pattern
    int stall_mode = 0;
    int mode_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_fields.size() == 0)
                begin
                    $error("result with nothing expected");
                    failed = 1'b1;
                end
                else
                begin
                    field_result_t e;
                    e = expected_fields.pop_front();
                    if (accel_x !== e.ax)
                    begin
                        $error("accel_x expected %h got %h", e.ax, accel_x);
                        failed = 1'b1;
                    end
                    if (accel_y !== e.ay)
                    begin
                        $error("accel_y expected %h got %h", e.ay, accel_y);
                        failed = 1'b1;
                    end
                    if (accel_z !== e.az)
                    begin
                        $error("accel_z expected %h got %h", e.az, accel_z);
                        failed = 1'b1;
                    end
                    if (potential !== e.pot)
                    begin
                        $error("potential expected %h got %h", e.pot, potential);
                        failed = 1'b1;
                    end
                end
            end
            if (mode_cycles == 0)
            begin
                stall_mode <= $urandom_range(0, 2);
                mode_cycles <= $urandom_range(20, 200);
            end
            else
                mode_cycles <= mode_cycles - 1;
            case (stall_mode)
                0: pop <= 1'b1;
                1: pop <= ($urandom_range(0, 1) == 0);
                default: pop <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    task automatic write_reg(sgds_pkg::cfg_index_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            sgds_pkg::CFG_PARTICLE_COUNT: cur_count = val[10:0];
            sgds_pkg::CFG_SOFTENING_SQ:   cur_eps2 = 64'(val);
            sgds_pkg::CFG_PARTICLE_MASS:  cur_mass = 64'(val);
            default:                      cur_offset = 64'(val);
        endcase
    endtask

    task automatic set_config(logic [10:0] cnt, logic [31:0] eps2, logic [31:0] mass,
                              logic [31:0] offs);
        write_reg(sgds_pkg::CFG_PARTICLE_COUNT, 32'(cnt));
        write_reg(sgds_pkg::CFG_SOFTENING_SQ, eps2);
        write_reg(sgds_pkg::CFG_PARTICLE_MASS, mass);
        write_reg(sgds_pkg::CFG_SELF_POTENTIAL, offs);
    endtask

    task automatic add_store(int s, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        pending_items.push_back('{sgds_pkg::OP_STORE, 10'(s), x, y, z});
        slot_written[s] = 1'b1;
    endtask

    task automatic add_query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        pending_items.push_back('{sgds_pkg::OP_QUERY, 10'd0, x, y, z});
    endtask

    // hold until everything sent has been answered, then let stores settle
    task automatic drain();
        while (pending_items.size() != 0 || push || expected_fields.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic int written_prefix();
        int k;
        k = 0;
        while (k < TABLE_DEPTH && slot_written[k])
            k++;
        return k;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                                 : 32'h8000_0000 + $urandom_range(0, 255);
            3:       return 32'($signed($urandom_range(0, 511)) - 256);
            default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
        endcase
    endfunction

    function automatic logic [31:0] rand_word(logic [31:0] dflt);
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return dflt;
            3:       return $urandom_range(0, 65535);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        int lim, cnt;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty sum returns the offset alone
        set_config(11'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_store(0, 32'd0, 32'd0, 32'd0);
        add_store(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_store(2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_store(3, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000);
        for (int i = 4; i < 8; i++)
            add_store(i, rand_coord(), rand_coord(), rand_coord());
        add_query(32'd0, 32'd0, 32'd0);
        drain();

        // coincident point with no softening, heavy mass for saturation
        set_config(11'd8, 32'd0, 32'hFFFF_FFFF, 32'd0);
        add_query(32'd0, 32'd0, 32'd0);
        add_query(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        add_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        add_query(32'd1, 32'd0, 32'd0);
        add_query(32'd3, 32'h0000_0100, 32'hFFFF_FF00);
        drain();

        set_config(11'd1, 32'hFFFF_FFFF, 32'd0, 32'h1234_5678);
        add_query(32'd5, 32'd5, 32'd5);
        drain();
        set_config(11'd8, 32'd7, 32'd8589934, 32'd0);
        for (int i = 0; i < 4; i++)
            add_query(rand_coord(), rand_coord(), rand_coord());
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            lim = written_prefix();
            cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, (lim < 24) ? lim : 24);
            set_config(11'(cnt), rand_word(32'd7), rand_word(32'd8589934), $urandom());
            for (int i = 0; i < 55; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    lim = written_prefix() + 4;
                    add_store($urandom_range(0, (lim > 1023) ? 1023 : lim),
                              rand_coord(), rand_coord(), rand_coord());
                end
                else
                    add_query(rand_coord(), rand_coord(), rand_coord());
            end
            drain();
        end

        // longest walk over the unbroken run of slots written from slot 0
        set_config(11'(written_prefix()), 32'd7, 32'd8589934, 32'd0);
        add_query(rand_coord(), rand_coord(), rand_coord());
        add_query(32'd0, 32'd0, 32'd0);
        drain();

        if (!failed && expected_fields.size() == 0)
            $display("tb_softened_gravity_direct_sum_core passed");
        else
            $display("tb_softened_gravity_direct_sum_core failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb_softened_gravity_direct_sum_core failed");
        $finish;
    end

endmodule
